FILE: rtl/core/triangle_box_overlap_test_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle/box overlap block
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BOX_OVERLAP_TEST_DEFINES_SVH
`define TRIANGLE_BOX_OVERLAP_TEST_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TBO_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define TBO_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants and types of the triangle/box overlap block.
// ----------------------------------------------------------------------------
package tbo_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 6;
   localparam int HALF_W          = 16;
   localparam int NUM_CELLS       = 9;
   localparam int CELL_DEPTH      = 2;
   localparam int CHAIN_DEPTH     = NUM_CELLS * CELL_DEPTH;
   localparam int NORM_DEPTH      = 6;
   localparam int RSP_W           = 8;

   typedef struct packed {
      logic valid;
      logic hit;
   } ctl_type;

endpackage

FILE: rtl/core/tbo_cell.sv
// ----------------------------------------------------------------------------
// tbo_cell
// One edge-cross axis test; forwards the triangle to the next cell.
// ----------------------------------------------------------------------------
module tbo_cell #(
   parameter int CW   = tbo_pkg::COORD_WIDTH_DEF,
   parameter int AXIS = 0,
   parameter int EDGE = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [tbo_pkg::HALF_W-1:0]         half,
   input  tbo_pkg::ctl_type                   ctl_i,
   input  logic [8:0][CW-1:0]                 v_i,
   input  logic [8:0][CW:0]                   f_i,
   output tbo_pkg::ctl_type                   ctl_o,
   output logic [8:0][CW-1:0]                 v_o,
   output logic [8:0][CW:0]                   f_o
);
   localparam int EW = CW + 1;
   localparam int MW = CW + EW;
   localparam int RW = EW + 1 + tbo_pkg::HALF_W;
   localparam int XW = CW + EW + 18;
   localparam int I1 = (AXIS + 1) % 3;
   localparam int I2 = (AXIS + 2) % 3;

   tbo_pkg::ctl_type       ctl_a_ff, ctl_b_ff;
   logic [8:0][CW-1:0]     v_a_ff, v_b_ff;
   logic [8:0][EW-1:0]     f_a_ff, f_b_ff;
   logic signed [MW-1:0]   m1_in [3], m2_in [3], m1_a_ff [3], m2_a_ff [3];
   logic [RW-1:0]          rad_in, rad_a_ff;
   logic signed [EW-1:0]   fa1, fa2;
   logic [EW-1:0]          abs1, abs2;
   logic [EW:0]            rsum;
   logic signed [XW-1:0]   p [3];
   logic signed [XW-1:0]   lo, hi, rs;
   logic                   sep;

   // axis = unit(AXIS) x edge(EDGE): proj = v[I2]*f[I1] - v[I1]*f[I2]
   always_comb begin
      fa1  = $signed(f_i[EDGE*3+I1]);
      fa2  = $signed(f_i[EDGE*3+I2]);
      abs1 = fa1[EW-1] ? EW'(-fa1) : EW'(fa1);
      abs2 = fa2[EW-1] ? EW'(-fa2) : EW'(fa2);
      rsum = {1'b0, abs1} + {1'b0, abs2};
      rad_in = rsum * half;
      for (int i = 0; i < 3; i++) begin
         m1_in[i] = $signed(v_i[i*3+I2]) * fa1;
         m2_in[i] = $signed(v_i[i*3+I1]) * fa2;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p[i] = m1_a_ff[i];
         p[i] = p[i] - m2_a_ff[i];
      end
      lo = p[0];
      hi = p[0];
      for (int i = 1; i < 3; i++) begin
         if (p[i] < lo) lo = p[i];
         if (p[i] > hi) hi = p[i];
      end
      rs  = $signed({{(XW-RW){1'b0}}, rad_a_ff});
      sep = (rs < lo) || (hi < -rs);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_a_ff.hit <= ctl_i.hit;
         v_a_ff       <= v_i;
         f_a_ff       <= f_i;
         m1_a_ff      <= m1_in;
         m2_a_ff      <= m2_in;
         rad_a_ff     <= rad_in;
         ctl_b_ff.hit <= ctl_a_ff.hit & ~sep;
         v_b_ff       <= v_a_ff;
         f_b_ff       <= f_a_ff;
      end
      if (reset) begin
         ctl_a_ff.valid <= 1'b0;
         ctl_b_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_a_ff.valid <= ctl_i.valid;
         ctl_b_ff.valid <= ctl_a_ff.valid;
      end
   end

   assign ctl_o = ctl_b_ff;
   assign v_o   = v_b_ff;
   assign f_o   = f_b_ff;

endmodule

FILE: rtl/core/tbo_normal.sv
// ----------------------------------------------------------------------------
// tbo_normal
// Triangle normal axis test, split multiplies, aligned to the cell chain.
// ----------------------------------------------------------------------------
module tbo_normal #(
   parameter int CW = tbo_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [tbo_pkg::HALF_W-1:0] half,
   input  logic [8:0][CW-1:0]         v_i,
   input  logic [8:0][CW:0]           f_i,
   output logic                       hit_o
);
   localparam int EW  = CW + 1;
   localparam int PW  = 2 * EW;
   localparam int NW  = 2 * EW + 1;
   localparam int NLO = (NW + 1) / 2;
   localparam int NHI = NW - NLO;
   localparam int SW  = NW + 2;
   localparam int RLO = (SW + 1) / 2;
   localparam int RHI = SW - RLO;
   localparam int HW  = tbo_pkg::HALF_W;
   localparam int XW  = CW + NW + 18;
   localparam int DL  = tbo_pkg::CHAIN_DEPTH - tbo_pkg::NORM_DEPTH;

   logic [8:0][CW-1:0]        v1_ff, v2_ff;
   logic signed [PW-1:0]      pr_in [6], pr_ff [6];
   logic signed [NW-1:0]      n_in [3], n_ff [3];
   logic [SW-1:0]             rs_in, rs_ff;
   logic signed [CW+NLO:0]    lpp_in [9], lpp_ff [9];
   logic signed [CW+NHI-1:0]  hpp_in [9], hpp_ff [9];
   logic signed [XW-1:0]      comp_in [9], comp_ff [9];
   logic [RLO+HW-1:0]         rl_in, rl_ff;
   logic [RHI+HW-1:0]         rh_in, rh_ff;
   logic signed [XW-1:0]      p_in [3], p_ff [3];
   logic signed [XW-1:0]      r_in, r_ff, r6_ff, lo_in, hi_in, lo_ff, hi_ff;
   logic                      hit_in;
   logic [DL-1:0]             dly_ff;
   logic signed [EW-1:0]      e0 [3], e1 [3];
   logic [NW-1:0]             na [3];
   logic signed [XW-1:0]      t;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         e0[j] = $signed(f_i[j]);
         e1[j] = $signed(f_i[3+j]);
      end
      pr_in[0] = e0[1] * e1[2];
      pr_in[1] = e0[2] * e1[1];
      pr_in[2] = e0[2] * e1[0];
      pr_in[3] = e0[0] * e1[2];
      pr_in[4] = e0[0] * e1[1];
      pr_in[5] = e0[1] * e1[0];
      for (int j = 0; j < 3; j++) begin
         n_in[j] = pr_ff[2*j];
         n_in[j] = n_in[j] - pr_ff[2*j+1];
      end
   end

   // n = hi * 2^NLO + lo, lo unsigned
   always_comb begin
      rs_in = '0;
      for (int j = 0; j < 3; j++) begin
         na[j] = n_ff[j][NW-1] ? NW'(-n_ff[j]) : NW'(n_ff[j]);
         rs_in = rs_in + SW'(na[j]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lpp_in[i*3+j] = $signed(v2_ff[i*3+j]) * $signed({1'b0, n_ff[j][NLO-1:0]});
            hpp_in[i*3+j] = $signed(v2_ff[i*3+j]) * $signed(n_ff[j][NW-1:NLO]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         t          = hpp_ff[k];
         t          = t <<< NLO;
         comp_in[k] = t + lpp_ff[k];
      end
      rl_in = rs_ff[RLO-1:0] * half;
      rh_in = rs_ff[SW-1:RLO] * half;
      for (int i = 0; i < 3; i++)
         p_in[i] = comp_ff[i*3] + comp_ff[i*3+1] + comp_ff[i*3+2];
      r_in = $signed({{(XW-RHI-HW){1'b0}}, rh_ff});
      r_in = (r_in <<< RLO) + $signed({{(XW-RLO-HW){1'b0}}, rl_ff});
      lo_in = p_ff[0];
      hi_in = p_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (p_ff[i] < lo_in) lo_in = p_ff[i];
         if (p_ff[i] > hi_in) hi_in = p_ff[i];
      end
      hit_in = !((r6_ff < lo_ff) || (hi_ff < -r6_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff   <= pr_in;
         v1_ff   <= v_i;
         n_ff    <= n_in;
         v2_ff   <= v1_ff;
         rs_ff   <= rs_in;
         lpp_ff  <= lpp_in;
         hpp_ff  <= hpp_in;
         comp_ff <= comp_in;
         rl_ff   <= rl_in;
         rh_ff   <= rh_in;
         p_ff    <= p_in;
         r_ff    <= r_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         r6_ff   <= r_ff;
         dly_ff  <= {dly_ff[DL-2:0], hit_in};
      end
   end

   assign hit_o = dly_ff[DL-1];

endmodule

FILE: rtl/core/triangle_box_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating axis test of a triangle against a cube centered at the origin.
// ----------------------------------------------------------------------------
// Throughput: one triangle per cycle unless the output queue is full.
// A chain of nine axis cells, two register stages each, runs beside a
// six-stage normal-axis unit.
// A two-entry output queue keeps input open while one result waits.
// Synchronous reset empties the pipe and queue, half extent back to 2.0.
module triangle_box_overlap_test #(
   parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = tbo_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // overlaps, zero pad
   output logic [tbo_pkg::RSP_W-1:0]            rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbo_pkg::HALF_W-1:0]           csr_data
);
`include "triangle_box_overlap_test_defines.svh"

   localparam int CW = COORD_WIDTH;
   localparam int EW = CW + 1;
   localparam int UW = CW + 18;
   localparam int NC = tbo_pkg::NUM_CELLS;

   logic [tbo_pkg::HALF_W-1:0] half_ff;
   logic                       adv;
   logic [8:0][CW-1:0]         v_in;
   logic [8:0][EW-1:0]         f_in;
   logic                       uhit_in;
   tbo_pkg::ctl_type           ctl0_ff;
   logic [8:0][CW-1:0]         v0_ff;
   logic [8:0][EW-1:0]         f0_ff;
   tbo_pkg::ctl_type           ctl_c [NC+1];
   logic [8:0][CW-1:0]         v_c [NC+1];
   logic [8:0][EW-1:0]         f_c [NC+1];
   logic                       nhit;
   logic                       res_bit;
   logic                       wr, rd;
   logic [1:0]                 cnt_ff;
   logic                       wp_ff, rp_ff;
   logic                       q_ff [2];
   logic signed [CW-1:0]       mn, mx, cv;
   logic signed [UW-1:0]       hs;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) half_ff <= tbo_pkg::HALF_W'(32'd2 << FRAC_BITS);
      else if (csr_valid) half_ff <= csr_data;
   end

   assign adv        = (cnt_ff != 2'd2);
   assign req_tready = adv;

   // unpack, edges, unit axis tests
   always_comb begin
      for (int k = 0; k < 9; k++) v_in[k] = req_tdata[k*CW +: CW];
      for (int j = 0; j < 3; j++) begin
         f_in[j]   = EW'($signed(v_in[3+j]) - $signed(v_in[j]));
         f_in[3+j] = EW'($signed(v_in[6+j]) - $signed(v_in[3+j]));
         f_in[6+j] = EW'($signed(v_in[j])   - $signed(v_in[6+j]));
      end
      hs      = $signed({{(UW-tbo_pkg::HALF_W){1'b0}}, half_ff});
      uhit_in = 1'b1;
      for (int j = 0; j < 3; j++) begin
         mn = $signed(v_in[j]);
         mx = $signed(v_in[j]);
         for (int i = 1; i < 3; i++) begin
            cv = $signed(v_in[i*3+j]);
            if (cv < mn) mn = cv;
            if (cv > mx) mx = cv;
         end
         if ((hs < UW'(mn)) || (UW'(mx) < -hs)) uhit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl0_ff.hit <= uhit_in;
         v0_ff       <= v_in;
         f0_ff       <= f_in;
      end
      if (reset) ctl0_ff.valid <= 1'b0;
      else if (adv) ctl0_ff.valid <= req_tvalid;
   end

   assign ctl_c[0] = ctl0_ff;
   assign v_c[0]   = v0_ff;
   assign f_c[0]   = f0_ff;

   for (genvar c = 0; c < NC; c++) begin : g_cell
      tbo_cell #(.CW(CW), .AXIS(c / 3), .EDGE(c % 3)) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .half  (half_ff),
         .ctl_i (ctl_c[c]),
         .v_i   (v_c[c]),
         .f_i   (f_c[c]),
         .ctl_o (ctl_c[c+1]),
         .v_o   (v_c[c+1]),
         .f_o   (f_c[c+1])
      );
   end

   tbo_normal #(.CW(CW)) u_normal (
      .clock (clock),
      .adv   (adv),
      .half  (half_ff),
      .v_i   (v_c[0]),
      .f_i   (f_c[0]),
      .hit_o (nhit)
   );

   assign res_bit = ctl_c[NC].hit & nhit & (v_c[NC] == v_c[NC]) & (f_c[NC] == f_c[NC]);
   assign wr      = ctl_c[NC].valid & adv;
   assign rd      = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) q_ff[wp_ff] <= res_bit;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {{(tbo_pkg::RSP_W-1){1'b0}}, q_ff[rp_ff]};

   `TBO_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `TBO_ASSERT_IMP(a_full_stall, clock, reset, cnt_ff == 2'd2, !req_tready)
   `TBO_ASSERT_NXT(a_wr_shows, clock, reset, wr, rsp_tvalid)

endmodule
